// ----- rtl/pbig_pkg.sv -----
// Shared types and constants for the periodic boundary image generator.
`timescale 1ns / 1ps

package pbig_pkg;

  localparam int COORD_W       = 32;
  localparam int LEN_W         = 31;
  localparam int IDX_W         = 16;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int IN_TDATA_W    = 96;
  localparam int OUT_TDATA_W   = 112;
  localparam int MAX_ATOMS_DEF = 65536;

  localparam logic [LEN_W-1:0] LEN_RESET = 31'd65536;

  typedef enum logic [2:0] {
    REG_LOW_X = 3'd0,
    REG_LOW_Y = 3'd1,
    REG_LOW_Z = 3'd2,
    REG_LEN_X = 3'd3,
    REG_LEN_Y = 3'd4,
    REG_LEN_Z = 3'd5,
    REG_SKIN  = 3'd6,
    REG_FRAC  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] low;
    logic [2:0][LEN_W-1:0]   len;
    logic [LEN_W-1:0]        skin;
    logic                    frac;
  } cfg_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] pos;
    logic [2:0][COORD_W-1:0] img1;
    logic [2:0][COORD_W-1:0] img2;
    logic [2:0]              hi;
    logic [2:0]              lo;
    logic [IDX_W-1:0]        idx;
  } item_t;

endpackage

// ----- rtl/pbig_regs.sv -----
// APB configuration registers for the periodic boundary image generator.
`timescale 1ns / 1ps

module pbig_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pbig_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [pbig_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [pbig_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output pbig_pkg::cfg_t                cfg
);

  pbig_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low  <= '0;
      cfg_r.len  <= {3{pbig_pkg::LEN_RESET}};
      cfg_r.skin <= '0;
      cfg_r.frac <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        pbig_pkg::REG_LOW_X: cfg_r.low[0] <= cfg_pwdata;
        pbig_pkg::REG_LOW_Y: cfg_r.low[1] <= cfg_pwdata;
        pbig_pkg::REG_LOW_Z: cfg_r.low[2] <= cfg_pwdata;
        pbig_pkg::REG_LEN_X: cfg_r.len[0] <= cfg_pwdata[30:0];
        pbig_pkg::REG_LEN_Y: cfg_r.len[1] <= cfg_pwdata[30:0];
        pbig_pkg::REG_LEN_Z: cfg_r.len[2] <= cfg_pwdata[30:0];
        pbig_pkg::REG_SKIN:  cfg_r.skin   <= cfg_pwdata[30:0];
        pbig_pkg::REG_FRAC:  cfg_r.frac   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pbig_pkg::REG_LOW_X: cfg_prdata = cfg_r.low[0];
      pbig_pkg::REG_LOW_Y: cfg_prdata = cfg_r.low[1];
      pbig_pkg::REG_LOW_Z: cfg_prdata = cfg_r.low[2];
      pbig_pkg::REG_LEN_X: cfg_prdata = {1'b0, cfg_r.len[0]};
      pbig_pkg::REG_LEN_Y: cfg_prdata = {1'b0, cfg_r.len[1]};
      pbig_pkg::REG_LEN_Z: cfg_prdata = {1'b0, cfg_r.len[2]};
      pbig_pkg::REG_SKIN:  cfg_prdata = {1'b0, cfg_r.skin};
      pbig_pkg::REG_FRAC:  cfg_prdata = {31'd0, cfg_r.frac};
      default:             cfg_prdata = '0;
    endcase
  end

endmodule

// ----- rtl/pbig_expand.sv -----
// Image sequencer: walks one atom's images in result order, one beat a cycle while out_ready is high.
`timescale 1ns / 1ps

module pbig_expand (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pbig_pkg::item_t                   in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pbig_pkg::OUT_TDATA_W-1:0]  out_data,
  output logic                              out_image,
  output logic                              out_last
);

  typedef struct packed {
    logic       zp;
    logic       yp;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
  } cursor_t;

  logic            v_r;
  pbig_pkg::item_t item_r;
  cursor_t         cur_r;
  cursor_t         cur_nxt;
  logic            done;
  logic [1:0]      cx_m1, cy_m1, cz_m1;
  logic            l1_yp, l1_end;
  logic [1:0]      l1_i, l1_j;
  logic            take;
  logic [2:0][1:0] sel;
  logic [2:0][pbig_pkg::COORD_W-1:0] val;

  assign cx_m1 = {1'b0, item_r.hi[0]} + {1'b0, item_r.lo[0]};
  assign cy_m1 = {1'b0, item_r.hi[1]} + {1'b0, item_r.lo[1]};
  assign cz_m1 = {1'b0, item_r.hi[2]} + {1'b0, item_r.lo[2]};

  always_comb begin
    l1_yp  = cur_r.yp;
    l1_i   = cur_r.i;
    l1_j   = cur_r.j;
    l1_end = 1'b0;
    if (!cur_r.yp) begin
      if (cur_r.i != cx_m1) begin
        l1_i = cur_r.i + 2'd1;
      end else if (cy_m1 != 2'd0) begin
        l1_yp = 1'b1;
        l1_i  = 2'd0;
        l1_j  = 2'd1;
      end else begin
        l1_end = 1'b1;
      end
    end else begin
      if (cur_r.j != cy_m1) begin
        l1_j = cur_r.j + 2'd1;
      end else if (cur_r.i != cx_m1) begin
        l1_i = cur_r.i + 2'd1;
        l1_j = 2'd1;
      end else begin
        l1_end = 1'b1;
      end
    end
  end

  always_comb begin
    cur_nxt = cur_r;
    done    = 1'b0;
    if (!cur_r.zp) begin
      cur_nxt.yp = l1_yp;
      cur_nxt.i  = l1_i;
      cur_nxt.j  = l1_j;
      if (l1_end) begin
        if (cz_m1 != 2'd0) begin
          cur_nxt = '{zp: 1'b1, yp: 1'b0, i: 2'd0, j: 2'd0, k: 2'd1};
        end else begin
          done = 1'b1;
        end
      end
    end else if (cur_r.k != cz_m1) begin
      cur_nxt.k = cur_r.k + 2'd1;
    end else begin
      cur_nxt.yp = l1_yp;
      cur_nxt.i  = l1_i;
      cur_nxt.j  = l1_j;
      cur_nxt.k  = 2'd1;
      done       = l1_end;
    end
  end

  assign sel = {cur_r.k, cur_r.j, cur_r.i};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      case (sel[a])
        2'd0:    val[a] = item_r.pos[a];
        2'd1:    val[a] = item_r.img1[a];
        default: val[a] = item_r.img2[a];
      endcase
    end
  end

  assign take      = v_r && out_ready;
  assign in_ready  = !v_r || (out_ready && done);
  assign out_valid = v_r;
  assign out_last  = done;
  assign out_image = (cur_r != '0);
  assign out_data  = {item_r.idx, val[2], val[1], val[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      cur_r <= '0;
    end else if (in_valid && in_ready) begin
      v_r   <= 1'b1;
      cur_r <= '0;
    end else if (take) begin
      if (done) begin
        v_r <= 1'b0;
      end
      cur_r <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- rtl/periodic_boundary_image_generator.sv -----
// Top level of the periodic boundary image generator.
`timescale 1ns / 1ps
//
// One atom position enters per in_ beat: pos_x, pos_y, pos_z in Q16.16 and
// tlast marking the last atom of a frame. Each atom leaves as a run of out_
// beats: the atom itself first, then its periodic images, all carrying the
// atom's index within the frame; tuser flags an image, tlast ends the run.
// The box and skin sit in APB registers, to be written by the user only while
// the block idles; the block does not enforce this. Three register stages
// (scale multiply, offset, threshold test and image add) feed the image
// sequencer, which offers a run's first beat after taking its atom. It emits one
// beat per cycle while out_tready is high, so an atom holds the sequencer until
// its last result is taken and the block takes one atom per cycle while every
// run is a single beat. When out_tready is low the current beat holds and the
// stages fill; in_tready falls once all of them hold data. Reset empties the
// pipe, clears the atom index and restores the register defaults.

module periodic_boundary_image_generator #(
  parameter int MAX_ATOMS = pbig_pkg::MAX_ATOMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pbig_pkg::IN_TDATA_W-1:0]    in_tdata,   // pos_x, pos_y, pos_z
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pbig_pkg::OUT_TDATA_W-1:0]   out_tdata,  // out_x, out_y, out_z, origin_index
  output logic                               out_tuser,  // is_image
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pbig_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [pbig_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [pbig_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int CW = pbig_pkg::COORD_W;
  localparam int IW = pbig_pkg::IDX_W;

  pbig_pkg::cfg_t  cfg;
  pbig_pkg::item_t s3_item_r;
  pbig_pkg::item_t s3_item_nxt;

  logic [IW-1:0]       cnt_r;
  logic [IW:0]         cnt_inc;
  logic                in_take;

  logic                s1_v_r, s2_v_r, s3_v_r;
  logic                adv1, adv2, adv3, exp_ready;
  logic [2:0][CW-1:0]  s1_raw_r, s1_mid_r, s2_pos_r;
  logic [IW-1:0]       s1_idx_r, s2_idx_r;
  logic [2:0][CW-1:0]  mid_nxt, pos_nxt;
  logic signed [63:0]  prod [3];

  pbig_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  assign adv3      = !s3_v_r || exp_ready;
  assign adv2      = !s2_v_r || adv3;
  assign adv1      = !s1_v_r || adv2;
  assign in_tready = adv1;
  assign in_take   = in_tvalid && in_tready;
  assign cnt_inc   = {1'b0, cnt_r} + {{IW{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_take) begin
      if (in_tlast || (32'(cnt_inc) >= 32'(MAX_ATOMS))) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_inc[IW-1:0];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a]    = $signed(in_tdata[a*CW +: CW]) * $signed({1'b0, cfg.len[a]});
      mid_nxt[a] = prod[a][47:16];
      pos_nxt[a] = cfg.frac ? (s1_mid_r[a] + cfg.low[a]) : s1_raw_r[a];
    end
  end

  always_comb begin
    logic signed [33:0] c, th_hi, th_lo;
    s3_item_nxt     = s3_item_r;
    s3_item_nxt.idx = s2_idx_r;
    for (int a = 0; a < 3; a++) begin
      c     = 34'($signed(s2_pos_r[a]));
      th_hi = 34'($signed(cfg.low[a])) + 34'(cfg.len[a]) - 34'(cfg.skin);
      th_lo = 34'($signed(cfg.low[a])) + 34'(cfg.skin);
      s3_item_nxt.pos[a]  = s2_pos_r[a];
      s3_item_nxt.hi[a]   = (c > th_hi);
      s3_item_nxt.lo[a]   = (c < th_lo);
      s3_item_nxt.img2[a] = s2_pos_r[a] + {1'b0, cfg.len[a]};
      s3_item_nxt.img1[a] = (c > th_hi) ? (s2_pos_r[a] - {1'b0, cfg.len[a]})
                                        : (s2_pos_r[a] + {1'b0, cfg.len[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_tvalid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r <= in_tdata;
      s1_mid_r <= mid_nxt;
      s1_idx_r <= cnt_r;
    end
    if (adv2 && s1_v_r) begin
      s2_pos_r <= pos_nxt;
      s2_idx_r <= s1_idx_r;
    end
    if (adv3 && s2_v_r) begin
      s3_item_r <= s3_item_nxt;
    end
  end

  pbig_expand u_expand (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s3_v_r),
    .in_ready (exp_ready),
    .in_item  (s3_item_r),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata),
    .out_image(out_tuser),
    .out_last (out_tlast)
  );

endmodule

// ----- rtl/pbig_checker.sv -----
// Port-level checks for the periodic boundary image generator, with bind.
`timescale 1ns / 1ps

module pbig_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pbig_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  localparam int IW = pbig_pkg::IDX_W;
  localparam int IB = pbig_pkg::OUT_TDATA_W - IW;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat straight after reset");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tuser)
    else $error("run broken off or image flag missing");

  a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tdata[IB +: IW] == $past(out_tdata[IB +: IW]))
    else $error("origin index changed within a run");

endmodule

bind periodic_boundary_image_generator pbig_checker u_pbig_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
